// ===== src/lnled_pkg.sv =====
// lnled_pkg: shared types, character codes and helpers of the login name line editor
// no dependencies; imported by every module of the block

package lnled_pkg;

    localparam int NAME_LEN_W = 5;

    // input modes
    localparam logic [1:0] MODE_RX   = 2'd0;
    localparam logic [1:0] MODE_NEW  = 2'd1;
    localparam logic [1:0] MODE_READ = 2'd2;

    // status codes
    localparam logic [1:0] ST_EDIT  = 2'd0;
    localparam logic [1:0] ST_DONE  = 2'd1;
    localparam logic [1:0] ST_ABORT = 2'd2;
    localparam logic [1:0] ST_EOF   = 2'd3;

    // configuration register indexes
    localparam logic [2:0] CFG_ERASE  = 3'd0;
    localparam logic [2:0] CFG_KILL   = 3'd1;
    localparam logic [2:0] CFG_EOF    = 3'd2;
    localparam logic [2:0] CFG_IGNORE = 3'd3;
    localparam logic [2:0] CFG_ANYPAR = 3'd4;
    localparam logic [2:0] CFG_ODDPAR = 3'd5;
    localparam logic [2:0] CFG_FAST   = 3'd6;

    // characters
    localparam logic [6:0] CH_NUL  = 7'h00;
    localparam logic [6:0] CH_BS   = 7'h08;
    localparam logic [6:0] CH_LF   = 7'h0a;
    localparam logic [6:0] CH_CR   = 7'h0d;
    localparam logic [6:0] CH_SP   = 7'h20;
    localparam logic [6:0] CH_HASH = 7'h23;
    localparam logic [6:0] CH_AT   = 7'h40;
    localparam logic [6:0] CH_0    = 7'h30;
    localparam logic [6:0] CH_9    = 7'h39;
    localparam logic [6:0] CH_UA   = 7'h41;
    localparam logic [6:0] CH_UZ   = 7'h5a;
    localparam logic [6:0] CH_LA   = 7'h61;
    localparam logic [6:0] CH_LZ   = 7'h7a;
    localparam logic [6:0] CH_TILDE = 7'h7e;

    // reset values of the configuration registers
    localparam logic [6:0] RST_ERASE = 7'd35;
    localparam logic [6:0] RST_KILL  = 7'd64;
    localparam logic [6:0] RST_EOF   = 7'd4;

    // echo sequence of one item
    typedef enum logic [2:0] {
        ECHO_NONE      = 3'd0,
        ECHO_RAW       = 3'd1,
        ECHO_CRLF      = 3'd2,
        ECHO_RAW_CR    = 3'd3,
        ECHO_BSB       = 3'd4,
        ECHO_RAW_CRLF  = 3'd5,
        ECHO_RAW_BLANK = 3'd6
    } t_echo;

    typedef struct packed {
        logic [6:0] erase_char;
        logic [6:0] kill_char;
        logic [6:0] eof_char;
        logic       ignore_ctrl;
        logic       any_parity;
        logic       odd_parity;
        logic       fast_output;
    } t_cfg;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] rx_byte;
        logic [3:0] read_index;
    } t_in;

    typedef struct packed {
        logic [7:0]            tx_byte;
        logic                  tx_valid;
        logic                  last;
        logic [1:0]            status;
        logic [NAME_LEN_W-1:0] name_length;
        logic                  saw_upper;
        logic                  saw_lower;
        logic                  saw_digit;
        logic                  cr_ended;
        logic                  reprompt;
        logic [6:0]            name_char;
    } t_out;

    typedef struct packed {
        t_echo                 echo;
        logic [7:0]            raw;
        logic [1:0]            status;
        logic [NAME_LEN_W-1:0] name_length;
        logic                  saw_upper;
        logic                  saw_lower;
        logic                  saw_digit;
        logic                  cr_ended;
        logic                  reprompt;
        logic [6:0]            name_char;
    } t_job;

    function automatic logic [7:0] add_parity(input logic [7:0] b, input logic any_par,
                                              input logic odd_par);
        logic [7:0] v;
        v = b;
        if (!any_par) begin
            v[7] = v[7] | (^b[6:0]);
            v[7] = v[7] ^ odd_par;
        end
        return v;
    endfunction

endpackage

// ===== src/lnled_decode.sv =====
// lnled_decode: line state, name store and the registered job of one beat
// depends on lnled_pkg

module lnled_decode import lnled_pkg::*; #(
    parameter int NAME_LEN = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cfg i_cfg,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in,
    input  logic i_job_done,
    output logic o_job_valid,
    output t_job o_job
);

    localparam int STORE_D = (NAME_LEN < 16) ? NAME_LEN : 16;
    localparam int IW      = $clog2(STORE_D);
    localparam int CW      = $clog2(NAME_LEN + 1);

    logic [6:0]    r_store [STORE_D];
    logic [CW-1:0] r_count, n_count;
    logic          r_upper, n_upper;
    logic          r_lower, n_lower;
    logic          r_digit, n_digit;
    logic          r_closed, n_closed;
    logic          r_job_valid;
    t_job          r_job, n_job;

    logic       accept;
    logic       wr_en;
    logic [6:0] c;

    assign o_in_ready  = !r_job_valid || i_job_done;
    assign accept      = i_in_valid && o_in_ready;
    assign o_job_valid = r_job_valid;
    assign o_job       = r_job;
    assign c           = i_in.rx_byte[6:0];

    always_comb begin
        n_count  = r_count;
        n_upper  = r_upper;
        n_lower  = r_lower;
        n_digit  = r_digit;
        n_closed = r_closed;
        wr_en    = 1'b0;
        n_job    = '0;
        n_job.echo   = ECHO_NONE;
        n_job.raw    = i_in.rx_byte;
        n_job.status = ST_EDIT;
        case (i_in.mode)
            MODE_NEW: begin
                n_count  = '0;
                n_upper  = 1'b0;
                n_lower  = 1'b0;
                n_digit  = 1'b0;
                n_closed = 1'b0;
            end
            MODE_READ: begin
                if (int'(i_in.read_index) < NAME_LEN) begin
                    n_job.name_char = r_store[i_in.read_index[IW-1:0]];
                end
            end
            MODE_RX: begin
                if (!r_closed) begin
                    if (c == CH_NUL) begin
                        n_count = '0;
                        n_upper = 1'b0;
                        n_lower = 1'b0;
                        n_digit = 1'b0;
                        n_job.status = ST_ABORT;
                    end else if (c == i_cfg.eof_char) begin
                        n_closed = 1'b1;
                        n_job.status = ST_EOF;
                    end else if (c == CH_CR || c == CH_LF) begin
                        n_closed = 1'b1;
                        n_job.echo     = ECHO_CRLF;
                        n_job.status   = ST_DONE;
                        n_job.cr_ended = (c == CH_CR);
                    end else if (!(c inside {[CH_LA:CH_LZ], [CH_UA:CH_UZ]}) &&
                                 (c == i_cfg.erase_char || c == CH_HASH || c == CH_BS)) begin
                        if (r_count != '0) begin
                            n_count    = r_count - CW'(1);
                            n_job.echo = i_cfg.fast_output ? ECHO_BSB : ECHO_RAW;
                        end
                    end else if (!(c inside {[CH_LA:CH_LZ], [CH_UA:CH_UZ]}) &&
                                 (c == i_cfg.kill_char || c == CH_AT)) begin
                        if (!i_cfg.fast_output) begin
                            n_job.echo = ECHO_RAW_CRLF;
                        end else if (r_count != '0) begin
                            n_job.echo = ECHO_RAW_BLANK;
                        end else begin
                            n_job.echo = ECHO_RAW_CR;
                        end
                        n_count = '0;
                        n_job.reprompt = 1'b1;
                    end else begin
                        if (c inside {[CH_LA:CH_LZ]}) begin
                            n_lower = 1'b1;
                        end else if (c inside {[CH_UA:CH_UZ]}) begin
                            n_upper = 1'b1;
                        end else if (c inside {[CH_0:CH_9]}) begin
                            n_digit = 1'b1;
                        end
                        if (!(i_cfg.ignore_ctrl && (c <= CH_SP || c > CH_TILDE))) begin
                            if (int'(r_count) < NAME_LEN) begin
                                wr_en   = (int'(r_count) < STORE_D);
                                n_count = r_count + CW'(1);
                            end
                            if (n_count >= CW'(NAME_LEN)) begin
                                n_closed     = 1'b1;
                                n_job.echo   = ECHO_RAW_CRLF;
                                n_job.status = ST_DONE;
                            end else begin
                                n_job.echo = ECHO_RAW;
                            end
                        end
                    end
                end
            end
            default: begin
            end
        endcase
        n_job.name_length = NAME_LEN_W'(n_count);
        n_job.saw_upper   = n_upper;
        n_job.saw_lower   = n_lower;
        n_job.saw_digit   = n_digit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_upper     <= 1'b0;
            r_lower     <= 1'b0;
            r_digit     <= 1'b0;
            r_closed    <= 1'b0;
            r_job_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count  <= n_count;
                r_upper  <= n_upper;
                r_lower  <= n_lower;
                r_digit  <= n_digit;
                r_closed <= n_closed;
            end
            if (o_in_ready) begin
                r_job_valid <= i_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_job <= n_job;
            if (wr_en) begin
                r_store[r_count[IW-1:0]] <= c;
            end
        end
    end

endmodule

// ===== src/lnled_emit.sv =====
// lnled_emit: walks the echo sequence of a job and drives the result register
// depends on lnled_pkg

module lnled_emit import lnled_pkg::*; #(
    parameter int BLANK_RUN = 37
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cfg i_cfg,
    input  logic i_job_valid,
    input  t_job i_job,
    output logic o_job_done,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out
);

    localparam int SW = $clog2(BLANK_RUN + 3);

    logic [SW-1:0] r_step;
    logic          r_out_valid;
    t_out          r_out, n_out;
    logic [SW-1:0] len_m1;
    logic [7:0]    echo_byte;
    logic          ld;
    logic          at_last;

    assign ld          = !r_out_valid || i_out_ready;
    assign at_last     = (r_step == len_m1);
    assign o_job_done  = i_job_valid && ld && at_last;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_comb begin
        len_m1    = '0;
        echo_byte = 8'(CH_SP);
        case (i_job.echo)
            ECHO_NONE: begin
                echo_byte = '0;
            end
            ECHO_RAW: begin
                echo_byte = i_job.raw;
            end
            ECHO_CRLF: begin
                len_m1    = SW'(1);
                echo_byte = (r_step == '0) ? 8'(CH_CR) : 8'(CH_LF);
            end
            ECHO_RAW_CR: begin
                len_m1    = SW'(1);
                echo_byte = (r_step == '0) ? i_job.raw : 8'(CH_CR);
            end
            ECHO_BSB: begin
                len_m1    = SW'(2);
                echo_byte = (r_step == SW'(1)) ? 8'(CH_SP) : 8'(CH_BS);
            end
            ECHO_RAW_CRLF: begin
                len_m1 = SW'(2);
                if (r_step == '0) begin
                    echo_byte = i_job.raw;
                end else if (r_step == SW'(1)) begin
                    echo_byte = 8'(CH_CR);
                end else begin
                    echo_byte = 8'(CH_LF);
                end
            end
            ECHO_RAW_BLANK: begin
                len_m1 = SW'(BLANK_RUN + 2);
                if (r_step == '0) begin
                    echo_byte = i_job.raw;
                end else if (r_step == SW'(1) || r_step == len_m1) begin
                    echo_byte = 8'(CH_CR);
                end else begin
                    echo_byte = 8'(CH_SP);
                end
            end
            default: begin
                echo_byte = '0;
            end
        endcase
    end

    always_comb begin
        n_out             = '0;
        n_out.tx_valid    = (i_job.echo != ECHO_NONE);
        n_out.tx_byte     = n_out.tx_valid ?
                            add_parity(echo_byte, i_cfg.any_parity, i_cfg.odd_parity) : 8'd0;
        n_out.last        = at_last;
        n_out.status      = i_job.status;
        n_out.name_length = i_job.name_length;
        n_out.saw_upper   = i_job.saw_upper;
        n_out.saw_lower   = i_job.saw_lower;
        n_out.saw_digit   = i_job.saw_digit;
        n_out.cr_ended    = i_job.cr_ended;
        n_out.reprompt    = i_job.reprompt;
        n_out.name_char   = i_job.name_char;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else if (ld) begin
            r_out_valid <= i_job_valid;
            if (i_job_valid) begin
                r_step <= at_last ? '0 : r_step + SW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld && i_job_valid) begin
            r_out <= n_out;
        end
    end

endmodule

// ===== src/login_name_line_editor_unit.sv =====
// login_name_line_editor_unit: top level, configuration registers and assertions
// depends on lnled_pkg, lnled_decode, lnled_emit
// path: a taken input beat is registered as a job in lnled_decode, each result beat in lnled_emit
// throughput: one result beat per cycle unless i_out_ready stalls it; an item with n result beats
// (1 to BLANK_RUN+3) holds the echo sequencer until its last beat leaves, when the next item enters
// reset: synchronous active low; clears line state, flags and config to defaults, not the name store

module login_name_line_editor_unit import lnled_pkg::*; #(
    parameter int NAME_LEN  = 16,
    parameter int BLANK_RUN = 37
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic [2:0] i_cfg_idx,
    input  logic [6:0] i_cfg_wdata,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_in        i_in,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_out       o_out
);

    t_cfg r_cfg;
    logic w_job_valid;
    logic w_job_done;
    t_job w_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.erase_char  <= RST_ERASE;
            r_cfg.kill_char   <= RST_KILL;
            r_cfg.eof_char    <= RST_EOF;
            r_cfg.ignore_ctrl <= 1'b0;
            r_cfg.any_parity  <= 1'b1;
            r_cfg.odd_parity  <= 1'b0;
            r_cfg.fast_output <= 1'b1;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_idx)
                CFG_ERASE:  r_cfg.erase_char  <= i_cfg_wdata;
                CFG_KILL:   r_cfg.kill_char   <= i_cfg_wdata;
                CFG_EOF:    r_cfg.eof_char    <= i_cfg_wdata;
                CFG_IGNORE: r_cfg.ignore_ctrl <= i_cfg_wdata[0];
                CFG_ANYPAR: r_cfg.any_parity  <= i_cfg_wdata[0];
                CFG_ODDPAR: r_cfg.odd_parity  <= i_cfg_wdata[0];
                CFG_FAST:   r_cfg.fast_output <= i_cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    lnled_decode #(
        .NAME_LEN(NAME_LEN)
    ) u_decode (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in       (i_in),
        .i_job_done (w_job_done),
        .o_job_valid(w_job_valid),
        .o_job      (w_job)
    );

    lnled_emit #(
        .BLANK_RUN(BLANK_RUN)
    ) u_emit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_job_valid(w_job_valid),
        .i_job      (w_job),
        .o_job_done (w_job_done),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out      (o_out)
    );

    // no new input beat while the current echo sequence still has beats to go
    a_hold_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_job_valid && !w_job_done) |-> !o_in_ready)
        else $error("input taken while echo sequence pending");

    // a non-final beat is followed at once by another beat of the same item
    a_seq_cont: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && !o_out.last) |=>
        (o_out_valid && o_out.status == $past(o_out.status) &&
         o_out.name_length == $past(o_out.name_length)))
        else $error("echo sequence broken");

    // a beat without echo byte is always the only beat of its item
    a_silent_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out.tx_valid) |-> (o_out.last && o_out.tx_byte == 8'd0))
        else $error("silent beat not final");

endmodule
